// ===== hw/rtl/fedl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers for the feedback echo delay line.
package fedl_pkg;

  localparam int MEMORY_DEPTH_DEFAULT = 131072;

  localparam int SAMPLE_W    = 16;
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_INDEX_W = 2;
  localparam int PCT_W       = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PCT_W-1:0]           pct_t;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_RING_LENGTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_SAMPLES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_PCT  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_PCT    = 2'd3;

  localparam int   RESET_RING_LENGTH   = 96000;
  localparam int   RESET_DELAY_SAMPLES = 48000;
  localparam pct_t RESET_FEEDBACK_PCT  = 7'd50;
  localparam pct_t RESET_VOLUME_PCT    = 7'd50;

  localparam pct_t PCT_MAX = 7'd100;

  // x/100 as (x * RECIP) >> RECIP_SHIFT, exact for x < 2^22
  localparam int RECIP_SHIFT = 29;
  localparam int RECIP       = 5368710;
  localparam int COEF_W      = 30;
  localparam int MAG_W       = SAMPLE_W + 1;

  typedef logic [COEF_W-1:0] coef_t;

  // Output queue
  localparam int OQ_DEPTH = 3;
  localparam int OQ_AW    = 2;

  // Percent clamped to 100, folded with the reciprocal of 100
  function automatic coef_t pct_coef(input pct_t pct);
    pct_t        p;
    logic [31:0] full;
    p    = (pct > PCT_MAX) ? PCT_MAX : pct;
    full = 32'(p) * 32'(RECIP);
    return full[COEF_W-1:0];
  endfunction

  function automatic sample_t sat16(input logic signed [SAMPLE_W+1:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/fedl_ring_mem.sv =====
`timescale 1ns / 1ps
// Ring storage: one write port, one registered read port.
module fedl_ring_mem #(
  parameter int DEPTH = fedl_pkg::MEMORY_DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  fedl_pkg::sample_t        wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output fedl_pkg::sample_t        rdata
);
  import fedl_pkg::*;

  sample_t mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/fedl_mix.sv =====
`timescale 1ns / 1ps
// Scales the delayed sample by a percent coefficient and adds it to the input.
module fedl_mix (
  input  fedl_pkg::sample_t x,
  input  fedl_pkg::sample_t echo,
  input  fedl_pkg::coef_t   coef,
  output fedl_pkg::sample_t y
);
  import fedl_pkg::*;

  logic                           neg;
  logic [SAMPLE_W-1:0]            mag;
  logic [SAMPLE_W+COEF_W-1:0]     prod;
  logic [MAG_W-1:0]               q;
  logic signed [SAMPLE_W+1:0]     sq;
  logic signed [SAMPLE_W+1:0]     sum;

  // magnitude times coefficient truncates toward zero, sign restored after
  always_comb begin
    neg  = echo[SAMPLE_W-1];
    mag  = neg ? SAMPLE_W'(-echo) : SAMPLE_W'(echo);
    prod = (SAMPLE_W+COEF_W)'(mag) * (SAMPLE_W+COEF_W)'(coef);
    q    = prod[RECIP_SHIFT +: MAG_W];
    sq   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum  = {{2{x[SAMPLE_W-1]}}, x} + sq;
    y    = sat16(sum);
  end

endmodule

// ===== hw/rtl/fedl_out_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue between the datapath and the output channel.
module fedl_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  fedl_pkg::sample_t             push_data,
  output logic [fedl_pkg::OQ_AW-1:0]    count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fedl_pkg::sample_t             sample_out
);
  import fedl_pkg::*;

  sample_t            q [OQ_DEPTH];
  logic [OQ_AW-1:0]   head;
  logic [OQ_AW-1:0]   tail;
  logic [OQ_AW-1:0]   count_next;
  logic               pop;

  function automatic logic [OQ_AW-1:0] ptr_inc(input logic [OQ_AW-1:0] p);
    return (p == OQ_AW'(OQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  assign sample_out = q[head];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_data;
    end
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
    end
  end

endmodule

// ===== hw/rtl/feedback_echo_delay_line_unit.sv =====
`timescale 1ns / 1ps
// Top level of the feedback echo delay line.
//
// Input channel (in_valid/in_stall, sample_in) takes one signed audio sample
// per item; output channel (out_valid/out_stall, sample_out) returns one
// sample per item, in order. Configuration writes go through cfg_valid /
// cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
//
// An accepted item is held in the mix stage registers, then in the result
// queue, before it is on sample_out. Throughput is one item per cycle while
// in_stall is low, set by the single read-modify-write of the ring memory per
// item: read issued on accept, scale, mix and write-back in the next cycle,
// with the previous item's write forwarded when it hits the address being read.
//
// Reset: the ring memory is cleared one entry per cycle; in_stall stays high
// during that pass. Registers return to ring 96000, delay 48000, feedback 50%,
// volume 50%.
//
// A stalled receiver fills a three-entry result queue; in_stall rises when
// the queue plus the item in flight would overflow it.
module feedback_echo_delay_line_unit #(
  parameter int MEMORY_DEPTH = fedl_pkg::MEMORY_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fedl_pkg::sample_t                  sample_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fedl_pkg::sample_t                  sample_out,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fedl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fedl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fedl_pkg::*;

  localparam int AW = $clog2(MEMORY_DEPTH);
  localparam int LW = $clog2(MEMORY_DEPTH + 1);
  localparam int EW = LW + 1;

  function automatic logic [LW-1:0] clamp_len(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return LW'(1);
    end else if (32'(v) > 32'(MEMORY_DEPTH)) begin
      return LW'(MEMORY_DEPTH);
    end
    return LW'(v);
  endfunction

  function automatic logic [LW-1:0] clamp_delay(input logic [CFG_DATA_W-1:0] d,
                                                input logic [LW-1:0] len);
    return (32'(d) > 32'(len)) ? len : LW'(d);
  endfunction

  // Configuration, with derived values kept registered
  logic [CFG_DATA_W-1:0] delay_raw;
  logic [LW-1:0]         len_eff;
  logic [LW-1:0]         interval;
  coef_t                 fb_coef;
  coef_t                 vol_coef;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_raw <= CFG_DATA_W'(RESET_DELAY_SAMPLES);
      len_eff   <= clamp_len(CFG_DATA_W'(RESET_RING_LENGTH));
      interval  <= clamp_delay(CFG_DATA_W'(RESET_DELAY_SAMPLES),
                               clamp_len(CFG_DATA_W'(RESET_RING_LENGTH)));
      fb_coef   <= pct_coef(RESET_FEEDBACK_PCT);
      vol_coef  <= pct_coef(RESET_VOLUME_PCT);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RING_LENGTH: begin
          len_eff  <= clamp_len(cfg_data);
          interval <= clamp_delay(delay_raw, clamp_len(cfg_data));
        end
        REG_DELAY_SAMPLES: begin
          delay_raw <= cfg_data;
          interval  <= clamp_delay(cfg_data, len_eff);
        end
        REG_FEEDBACK_PCT: fb_coef  <= pct_coef(cfg_data[PCT_W-1:0]);
        REG_VOLUME_PCT:   vol_coef <= pct_coef(cfg_data[PCT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Clearing pass after reset
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(MEMORY_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Accept stage: positions and read address
  logic             in_accept;
  logic [OQ_AW-1:0] oq_count;
  logic [AW-1:0]    wp;
  logic [EW-1:0]    len_x;
  logic [EW-1:0]    int_x;
  logic [EW-1:0]    w_x;
  logic [EW-1:0]    w_inc;
  logic [AW-1:0]    wp_next;
  logic [AW-1:0]    rd_addr;
  logic             s1_valid;

  assign in_stall  = clearing ||
                     ((EW'(oq_count) + EW'(s1_valid)) >= EW'(OQ_DEPTH));
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    len_x = EW'(len_eff);
    int_x = EW'(interval);
    w_x   = (EW'(wp) >= len_x) ? '0 : EW'(wp);
    if (w_x >= int_x) begin
      rd_addr = AW'(w_x - int_x);
    end else begin
      rd_addr = AW'(w_x + len_x - int_x);
    end
    w_inc   = w_x + 1'b1;
    wp_next = (w_inc >= len_x) ? '0 : AW'(w_inc);
  end

  // Mix stage registers
  sample_t       s1_x;
  logic [AW-1:0] s1_w;
  logic          s1_fwd_hit;
  sample_t       s1_fwd_data;
  sample_t       rd_data;
  sample_t       echo;
  sample_t       y;
  sample_t       fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      s1_valid   <= 1'b0;
      s1_fwd_hit <= 1'b0;
    end else begin
      s1_valid <= in_accept;
      // the write by the item now in the mix stage lands after this read
      s1_fwd_hit <= s1_valid && in_accept && (rd_addr == s1_w);
      if (in_accept) begin
        wp <= wp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_fwd_data <= fb;
    if (in_accept) begin
      s1_x <= sample_in;
      s1_w <= AW'(w_x);
    end
  end

  assign echo = s1_fwd_hit ? s1_fwd_data : rd_data;

  fedl_ring_mem #(
    .DEPTH (MEMORY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (clearing || s1_valid),
    .waddr (clearing ? clr_addr : s1_w),
    .wdata (clearing ? sample_t'(0) : fb),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  fedl_mix u_mix_out (
    .x    (s1_x),
    .echo (echo),
    .coef (vol_coef),
    .y    (y)
  );

  fedl_mix u_mix_fb (
    .x    (s1_x),
    .echo (echo),
    .coef (fb_coef),
    .y    (fb)
  );

  fedl_out_fifo u_oq (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_data  (y),
    .count      (oq_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
  );

`ifndef NO_ASSERTIONS
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid)
    else $error("item in flight during ring clear");

  a_accept_reaches_mix: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted item lost before mix stage");

  a_write_inside_ring: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (EW'(s1_w) < len_x))
    else $error("ring write beyond ring length");

  a_queue_not_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (EW'(oq_count) < EW'(OQ_DEPTH)))
    else $error("result pushed into full queue");
`endif

endmodule

// ===== tb/feedback_echo_delay_line_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the feedback echo delay line: directed rows, then random phases.
module feedback_echo_delay_line_unit_tb;
  import fedl_pkg::*;

  localparam int DEPTH          = MEMORY_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3 * DEPTH;
  localparam int PHASES         = 16;
  localparam int PHASE_ITEMS    = 125;
  localparam int MAX_PRINTED    = 40;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [CFG_INDEX_W-1:0]      reg_idx;
    logic [CFG_DATA_W-1:0]       value;
    sample_t                     x;
    bit                          typed;
    sample_t                     want;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  sample_t                 sample_in;
  logic                    out_valid;
  logic                    out_stall;
  sample_t                 sample_out;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Echo model state
  sample_t                 ring_mem [DEPTH];
  int unsigned             wr_pos;
  logic [CFG_DATA_W-1:0]   ring_len_reg;
  logic [CFG_DATA_W-1:0]   delay_reg;
  pct_t                    fb_reg;
  pct_t                    vol_reg;

  sample_t                 echo_expect_q [$];
  stim_row_t               stim_rows [$];
  int                      mismatch_count;
  int                      result_idx;
  int                      send_idle_pct;
  int                      recv_stall_pct;
  int                      hold_req_cnt;

  feedback_echo_delay_line_unit #(
    .MEMORY_DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clip16(input int v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Truncates toward zero, percent capped at 100
  function automatic int pct_part(input int tap, input pct_t pct);
    int p;
    p = (pct > PCT_MAX) ? 100 : int'(pct);
    return (tap * p) / 100;
  endfunction

  // Predicts one output sample and updates the ring and write position
  function automatic sample_t echo_predict(input sample_t x);
    int unsigned len;
    int unsigned w;
    int unsigned span;
    int unsigned r;
    int          xi;
    int          tap;
    int          wet;
    int          fbk;
    len = ring_len_reg;
    if (len < 1) len = 1;
    if (len > DEPTH) len = DEPTH;
    w = wr_pos;
    if (w >= len) w = 0;
    span = delay_reg;
    if (span > len) span = len;
    r = (w >= span) ? (w - span) : (w + len - span);
    if (r >= len) r = r - len;
    xi  = x;
    tap = ring_mem[r];
    wet = clip16(xi + pct_part(tap, vol_reg));
    fbk = clip16(xi + pct_part(tap, fb_reg));
    ring_mem[w] = sample_t'(fbk);
    w = w + 1;
    if (w >= len) w = 0;
    wr_pos = w;
    return sample_t'(wet);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("[%0t] ERROR: %s", $time, what);
    end
  endtask

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (echo_expect_q.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with no item pending", sample_out));
      end else begin
        if (sample_out !== echo_expect_q[0]) begin
          report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                    result_idx, sample_out, echo_expect_q[0]));
        end
        void'(echo_expect_q.pop_front());
      end
      result_idx++;
    end
  end

  // Receiver: random stall, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("[%0t] ERROR: watchdog expired", $time);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_sample(input sample_t x, input bit typed, input sample_t want);
    sample_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    predicted = echo_predict(x);
    echo_expect_q.push_back(typed ? want : predicted);
  endtask

  // Stop offering items, wait for every result, then let the pipeline settle
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (echo_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RING_LENGTH:   ring_len_reg = value;
      REG_DELAY_SAMPLES: delay_reg    = value;
      REG_FEEDBACK_PCT:  fb_reg       = value[PCT_W-1:0];
      REG_VOLUME_PCT:    vol_reg      = value[PCT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(input sample_t x, input bit typed, input sample_t want);
    stim_row_t row;
    row.kind    = ROW_ITEM;
    row.reg_idx = REG_RING_LENGTH;
    row.value   = '0;
    row.x       = x;
    row.typed   = typed;
    row.want    = want;
    stim_rows.push_back(row);
  endtask

  task automatic add_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.value   = value;
    row.x       = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    stim_rows.push_back(row);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_pct();
    int k;
    k = $urandom_range(99);
    if (k < 15) return '0;
    if (k < 30) return CFG_DATA_W'(PCT_MAX);
    if (k < 40) return CFG_DATA_W'(127);
    if (k < 50) return CFG_DATA_W'($urandom_range(101, 127));
    return CFG_DATA_W'($urandom_range(0, 100));
  endfunction

  task automatic random_config();
    int                    k;
    logic [CFG_DATA_W-1:0] len;
    logic [CFG_DATA_W-1:0] dly;
    k = $urandom_range(99);
    if (k < 5)       len = '0;
    else if (k < 10) len = CFG_DATA_W'(1);
    else if (k < 15) len = CFG_DATA_W'($urandom_range(262143));
    else if (k < 20) len = CFG_DATA_W'(DEPTH);
    else             len = CFG_DATA_W'($urandom_range(2, 48));
    k = $urandom_range(99);
    if (k < 10)      dly = '0;
    else if (k < 20) dly = len;
    else if (k < 30) dly = CFG_DATA_W'($urandom_range(262143));
    else             dly = CFG_DATA_W'($urandom_range(0, 50));
    if ($urandom_range(3) != 0) write_reg(REG_RING_LENGTH, len);
    if ($urandom_range(3) != 0) write_reg(REG_DELAY_SAMPLES, dly);
    if ($urandom_range(3) != 0) write_reg(REG_FEEDBACK_PCT, pick_pct());
    if ($urandom_range(3) != 0) write_reg(REG_VOLUME_PCT, pick_pct());
  endtask

  function automatic sample_t random_sample();
    int k;
    k = $urandom_range(15);
    if (k == 0) return 16'sh7fff;
    if (k == 1) return 16'sh8000;
    if (k == 2) return sample_t'($urandom_range(0, 15) - 8);
    return sample_t'($urandom());
  endfunction

  initial begin
    stim_row_t row;
    rst            = 1'b1;
    in_valid       = 1'b0;
    sample_in      = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_cnt   = 0;
    mismatch_count = 0;
    result_idx     = 0;
    for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
    wr_pos       = 0;
    ring_len_reg = CFG_DATA_W'(RESET_RING_LENGTH);
    delay_reg    = CFG_DATA_W'(RESET_DELAY_SAMPLES);
    fb_reg       = RESET_FEEDBACK_PCT;
    vol_reg      = RESET_VOLUME_PCT;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Ring is clear after reset, so the echo adds nothing yet
    add_item(16'sd0,      1'b1, 16'sd0);
    add_item(16'sh7fff,   1'b1, 16'sh7fff);
    add_item(16'sh8000,   1'b1, 16'sh8000);
    add_item(-16'sd1,     1'b1, -16'sd1);
    // Ring length 0 acts as 1, zero delay, percents above 100
    add_reg(REG_RING_LENGTH, 18'd0);
    add_reg(REG_DELAY_SAMPLES, 18'd0);
    add_reg(REG_FEEDBACK_PCT, 18'd127);
    add_reg(REG_VOLUME_PCT, 18'd127);
    add_item(16'sh7fff,   1'b0, '0);
    add_item(16'sh7fff,   1'b0, '0);
    add_item(16'sh8000,   1'b0, '0);
    add_item(16'sh8000,   1'b0, '0);
    // Delay beyond ring length
    add_reg(REG_RING_LENGTH, 18'd8);
    add_reg(REG_DELAY_SAMPLES, 18'd200000);
    add_reg(REG_FEEDBACK_PCT, 18'd100);
    add_reg(REG_VOLUME_PCT, 18'd0);
    add_item(16'sd1000,   1'b0, '0);
    add_item(-16'sd1000,  1'b0, '0);
    add_item(16'sd1000,   1'b0, '0);
    // Ring shrinks to no more than the write position; ring contents kept
    add_reg(REG_RING_LENGTH, 18'd3);
    add_reg(REG_DELAY_SAMPLES, 18'd2);
    add_reg(REG_FEEDBACK_PCT, 18'd0);
    add_reg(REG_VOLUME_PCT, 18'd100);
    add_item(16'sd12345,  1'b0, '0);
    add_item(-16'sd12345, 1'b0, '0);
    add_item(16'sd100,    1'b0, '0);
    // Ring length above the memory depth, full-ring delay
    add_reg(REG_RING_LENGTH, 18'h3ffff);
    add_reg(REG_DELAY_SAMPLES, 18'(DEPTH));
    add_reg(REG_FEEDBACK_PCT, 18'd33);
    add_reg(REG_VOLUME_PCT, 18'd67);
    add_item(16'sh8000,   1'b0, '0);
    add_item(16'sh7fff,   1'b0, '0);
    add_item(16'sd7,      1'b0, '0);
    add_reg(REG_RING_LENGTH, 18'(DEPTH));
    add_reg(REG_DELAY_SAMPLES, 18'd1);
    add_item(16'sd5,      1'b0, '0);
    add_item(-16'sd5,     1'b0, '0);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_ITEM) begin
        send_sample(row.x, row.typed, row.want);
      end else begin
        quiesce();
        write_reg(row.reg_idx, row.value);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      random_config();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Long receiver hold-off while the sender keeps offering items
        if ((ph == 0 || ph == 8) && n == 10) hold_req_cnt++;
        // Sender waits for every result mid-phase
        if (ph == 5 && n == 60) quiesce();
        send_sample(random_sample(), 1'b0, '0);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (echo_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", echo_expect_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
